[design/cmbcp_pkg.sv]
// shared constants, types and codes of the colour-match braille cell packer
// no dependencies; imported by every module of the block
package cmbcp_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int CELL_COLUMNS = (MAX_WIDTH + 1) / 2;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int COLOR_W      = 8;
  localparam int SENS_W       = 9;
  localparam int GLYPH_W      = 14;
  localparam int DOTS_W       = 8;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CELL_W = $clog2(CELL_COLUMNS);

  // compare widths wide enough for both a counter and a size register
  localparam int XCMP_W = ((COL_W > WIDTH_REG_W) ? COL_W : WIDTH_REG_W) + 1;
  localparam int YCMP_W = ((ROW_W > HEIGHT_REG_W) ? ROW_W : HEIGHT_REG_W) + 1;

  localparam int SQ_W     = 2 * COLOR_W;
  localparam int DIST_W   = SQ_W + 2;
  localparam int SENSQ_W  = 2 * SENS_W;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = HEIGHT_REG_W;

  localparam int IN_TDATA_W  = 3 * COLOR_W;
  localparam int OUT_TDATA_W = ((GLYPH_W + 7) / 8) * 8;

  localparam logic [GLYPH_W-1:0] GLYPH_BASE = GLYPH_W'(14'h2800);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_TARGET_RED   = 3'd2,
    CFG_TARGET_GREEN = 3'd3,
    CFG_TARGET_BLUE  = 3'd4,
    CFG_SENSITIVITY  = 3'd5
  } cfg_index_t;

  // one classified pixel, as handed from the front to the back
  typedef struct packed {
    logic [CELL_W-1:0] cell_col;
    logic [DOTS_W-1:0] mask;
    logic              done;
    logic              line_end;
    logic              image_end;
  } cell_op_t;

endpackage

[design/color_match_braille_cell_packer.sv]
// top level of the colour-match braille cell packer: config registers, front, queue, back
// depends on cmbcp_pkg, cmbcp_front, cmbcp_queue, cmbcp_back
//
//   channel   direction  handshake              payload
//   pixels    in         s_tvalid / s_tready    s_tdata: red, green, blue
//   glyphs    out        m_tvalid / m_tready    m_tdata: glyph; m_tlast: line_end; m_tuser: image_end
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one pixel per cycle sustained while nothing stalls; the cell store does at most one read and one write each cycle
// the pixel that completes a cell passes the front stages, the queue and the back stage before its glyph is registered
// after reset all 512 columns of the cell store are swept clear with s_tready low
// a stalled m_tready fills the output register, the back stage, the four-entry
// queue and the two front stages before s_tready drops; config writes are always taken
module color_match_braille_cell_packer import cmbcp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [13:0] glyph, [15:14] zero
  output logic                   m_tlast,
  output logic                   m_tuser,   // [0] image_end
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [COLOR_W-1:0]      target_red;
  logic [COLOR_W-1:0]      target_green;
  logic [COLOR_W-1:0]      target_blue;
  logic [SENS_W-1:0]       sensitivity;

  logic               clearing;
  logic               f_valid, f_ready;
  cell_op_t           f_op;
  logic               q_valid, q_ready;
  cell_op_t           q_op;
  logic [GLYPH_W-1:0] glyph;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(1024);
      image_height <= HEIGHT_REG_W'(4096);
      target_red   <= '0;
      target_green <= '0;
      target_blue  <= '0;
      sensitivity  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        CFG_TARGET_RED:   target_red   <= cfg_data[COLOR_W-1:0];
        CFG_TARGET_GREEN: target_green <= cfg_data[COLOR_W-1:0];
        CFG_TARGET_BLUE:  target_blue  <= cfg_data[COLOR_W-1:0];
        CFG_SENSITIVITY:  sensitivity  <= cfg_data[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  cmbcp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .target_red   (target_red),
    .target_green (target_green),
    .target_blue  (target_blue),
    .sensitivity  (sensitivity),
    .hold         (clearing),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .red          (s_tdata[COLOR_W-1:0]),
    .green        (s_tdata[2*COLOR_W-1:COLOR_W]),
    .blue         (s_tdata[3*COLOR_W-1:2*COLOR_W]),
    .op_valid     (f_valid),
    .op_ready     (f_ready),
    .op           (f_op)
  );

  cmbcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_op)
  );

  cmbcp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .op_valid      (q_valid),
    .op_ready      (q_ready),
    .op            (q_op),
    .clearing      (clearing),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_glyph     (glyph),
    .out_line_end  (m_tlast),
    .out_image_end (m_tuser)
  );

  assign m_tdata = OUT_TDATA_W'(glyph);

endmodule

[design/cmbcp_front.sv]
// front end: pixel position tracking, dot selection and pipelined colour match
// depends on cmbcp_pkg
module cmbcp_front import cmbcp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [WIDTH_REG_W-1:0]  image_width,
  input  logic [HEIGHT_REG_W-1:0] image_height,
  input  logic [COLOR_W-1:0]      target_red,
  input  logic [COLOR_W-1:0]      target_green,
  input  logic [COLOR_W-1:0]      target_blue,
  input  logic [SENS_W-1:0]       sensitivity,
  input  logic                    hold,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COLOR_W-1:0]      red,
  input  logic [COLOR_W-1:0]      green,
  input  logic [COLOR_W-1:0]      blue,
  output logic                    op_valid,
  input  logic                    op_ready,
  output cell_op_t                op
);

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  logic [XCMP_W-1:0] w;
  logic [YCMP_W-1:0] h;
  logic [COL_W-1:0]  xs;
  logic [ROW_W-1:0]  ys;
  logic              last_col;
  logic              last_row;
  cell_op_t          info;

  logic             f1_valid;
  cell_op_t         f1_info;
  logic [COLOR_W-1:0] dr, dg, db;
  logic             f2_valid;
  cell_op_t         f2_info;
  logic [SQ_W-1:0]  sq_r, sq_g, sq_b;
  logic [SENSQ_W-1:0] sens_sq;
  logic [DIST_W-1:0]  dist_sq;
  logic             match;

  logic accept, f1_move, f2_move;

  function automatic logic [DOTS_W-1:0] dot_mask(input logic cx, input logic [1:0] ry);
    logic [2:0] idx;
    if (ry == 2'd3) begin
      idx = cx ? 3'd7 : 3'd6;
    end else begin
      idx = cx ? (3'({1'b0, ry}) + 3'd3) : {1'b0, ry};
    end
    return DOTS_W'(1) << idx;
  endfunction

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // zero acts as one, oversize saturates
  always_comb begin
    if (image_width == '0) begin
      w = XCMP_W'(1);
    end else if (XCMP_W'(image_width) > XCMP_W'(MAX_WIDTH)) begin
      w = XCMP_W'(MAX_WIDTH);
    end else begin
      w = XCMP_W'(image_width);
    end
    if (image_height == '0) begin
      h = YCMP_W'(1);
    end else if (YCMP_W'(image_height) > YCMP_W'(MAX_HEIGHT)) begin
      h = YCMP_W'(MAX_HEIGHT);
    end else begin
      h = YCMP_W'(image_height);
    end
  end

  // a count past the edge of a shrunk image counts as the last column or row
  always_comb begin
    xs = (XCMP_W'(column_count) >= w) ? COL_W'(w - XCMP_W'(1)) : column_count;
    ys = (YCMP_W'(row_count) >= h) ? ROW_W'(h - YCMP_W'(1)) : row_count;
    last_col = (XCMP_W'(xs) + XCMP_W'(1)) >= w;
    last_row = (YCMP_W'(ys) + YCMP_W'(1)) >= h;
    info.cell_col  = CELL_W'(xs >> 1);
    info.mask      = dot_mask(xs[0], ys[1:0]);
    info.done      = ((ys[1:0] == 2'd3) || last_row) && (xs[0] || last_col);
    info.line_end  = last_col;
    info.image_end = last_col && last_row;
  end

  assign f2_move  = f2_valid && op_ready;
  assign f1_move  = f1_valid && (!f2_valid || f2_move);
  assign in_ready = !hold && (!f1_valid || f1_move);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : ROW_W'(ys + ROW_W'(1));
      end else begin
        column_count <= COL_W'(xs + COL_W'(1));
        row_count    <= ys;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (accept) begin
        f1_valid <= 1'b1;
      end else if (f1_move) begin
        f1_valid <= 1'b0;
      end
      if (f1_move) begin
        f2_valid <= 1'b1;
      end else if (f2_move) begin
        f2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_info <= info;
      dr      <= abs_diff(red, target_red);
      dg      <= abs_diff(green, target_green);
      db      <= abs_diff(blue, target_blue);
    end
    if (f1_move) begin
      f2_info <= f1_info;
      sq_r    <= dr * dr;
      sq_g    <= dg * dg;
      sq_b    <= db * db;
    end
    sens_sq <= sensitivity * sensitivity;
  end

  assign dist_sq = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  assign match   = SENSQ_W'(dist_sq) <= sens_sq;

  always_comb begin
    op       = f2_info;
    op.mask  = match ? f2_info.mask : '0;
    op_valid = f2_valid;
  end

endmodule

[design/cmbcp_queue.sv]
// short queue of classified pixels between the front and the back
// depends on cmbcp_pkg
module cmbcp_queue import cmbcp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  cell_op_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output cell_op_t pop_data
);

  cell_op_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push, pop;

  assign push_ready = fill != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + QPTR_W'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + QPTR_W'(1));
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[design/cmbcp_back.sv]
// back end: per-column cell store with read-modify-write, glyph output register
// depends on cmbcp_pkg
module cmbcp_back import cmbcp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  input  cell_op_t           op,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [GLYPH_W-1:0] out_glyph,
  output logic               out_line_end,
  output logic               out_image_end
);

  logic [DOTS_W-1:0] cell_dots [CELL_COLUMNS];
  logic [CELL_W-1:0] clr_addr;

  logic              b_valid;
  cell_op_t          b_op;
  logic [DOTS_W-1:0] b_rdata;
  logic              b_fwd_hit;
  logic [DOTS_W-1:0] b_fwd_data;

  logic              out_free, b_leave, advance;
  logic [DOTS_W-1:0] merged;
  logic              we;
  logic [CELL_W-1:0] waddr;
  logic [DOTS_W-1:0] wdata;

  assign out_free = !out_valid || out_ready;
  assign b_leave  = b_valid && (!b_op.done || out_free);
  assign advance  = op_valid && !clearing && (!b_valid || b_leave);
  assign op_ready = advance;

  // the store read happens as the op enters, a write in that same cycle is forwarded
  assign merged = (b_fwd_hit ? b_fwd_data : b_rdata) | b_op.mask;
  assign we     = clearing || b_leave;
  assign waddr  = clearing ? clr_addr : b_op.cell_col;
  assign wdata  = (clearing || b_op.done) ? '0 : merged;

  always_ff @(posedge clk) begin
    if (we) begin
      cell_dots[waddr] <= wdata;
    end
    if (advance) begin
      b_rdata <= cell_dots[op.cell_col];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_op       <= op;
      b_fwd_hit  <= we && (waddr == op.cell_col);
      b_fwd_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= CELL_W'(clr_addr + CELL_W'(1));
      if (clr_addr == CELL_W'(CELL_COLUMNS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= 1'b1;
    end else if (b_leave) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_leave && b_op.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_leave && b_op.done) begin
      out_glyph     <= GLYPH_BASE + GLYPH_W'(merged);
      out_line_end  <= b_op.line_end;
      out_image_end <= b_op.image_end;
    end
  end

endmodule

[design/cmbcp_checker.sv]
// port-level checks on the colour-match braille cell packer, bound to the top level
// depends on cmbcp_pkg and color_match_braille_cell_packer
module cmbcp_checker import cmbcp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tlast,
  input logic                   m_tuser
);

  localparam logic [OUT_TDATA_W-1:0] GLYPH_HI_MASK = ~OUT_TDATA_W'(8'hFF);

  // store sweep keeps pixels out right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("pixel input open during store clear");

  // the last cell of an image also closes its text line
  a_image_end_is_line_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("image end without line end");

  // every glyph sits in the braille block
  a_glyph_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata & GLYPH_HI_MASK) == OUT_TDATA_W'(GLYPH_BASE)))
    else $error("glyph outside braille block");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                 && $stable(m_tuser)))
    else $error("stalled glyph beat changed");

endmodule

bind color_match_braille_cell_packer cmbcp_checker u_cmbcp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

[test/color_match_braille_cell_packer_tb.sv]
// self-checking bench for the colour-match braille cell packer: streams pixels, predicts each
// braille glyph with its line and image marks, and checks the glyph stream beat by beat
// depends on cmbcp_pkg and color_match_braille_cell_packer
module color_match_braille_cell_packer_tb;
  import cmbcp_pkg::*;

  localparam int RANDOM_PIXELS = 1800;
  localparam int CALM_PIXELS   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_TIME    = 15000000;

  // indexes that decode to no register
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               line_end;
    logic               image_end;
  } glyph_beat_t;

  class cell_glyph_tracker;
    logic [WIDTH_REG_W-1:0]  image_width;
    logic [HEIGHT_REG_W-1:0] image_height;
    logic [COLOR_W-1:0]      target_r, target_g, target_b;
    logic [SENS_W-1:0]       sensitivity;
    logic [DOTS_W-1:0]       cell_dots [CELL_COLUMNS];
    int unsigned             col_pos, row_pos;
    glyph_beat_t             expected_glyphs [$];
    int                      glyph_errors;

    function new();
      image_width  = WIDTH_REG_W'(MAX_WIDTH);
      image_height = HEIGHT_REG_W'(MAX_HEIGHT);
      target_r     = '0;
      target_g     = '0;
      target_b     = '0;
      sensitivity  = '0;
      foreach (cell_dots[i]) cell_dots[i] = '0;
      col_pos      = 0;
      row_pos      = 0;
      glyph_errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_IMAGE_WIDTH:  image_width  = value[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height = value[HEIGHT_REG_W-1:0];
        CFG_TARGET_RED:   target_r     = value[COLOR_W-1:0];
        CFG_TARGET_GREEN: target_g     = value[COLOR_W-1:0];
        CFG_TARGET_BLUE:  target_b     = value[COLOR_W-1:0];
        CFG_SENSITIVITY:  sensitivity  = value[SENS_W-1:0];
        default: ;
      endcase
    endfunction

    static function int unsigned dist_sq(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
    endfunction

    function void note_pixel(logic [IN_TDATA_W-1:0] px);
      int unsigned w, h, x, y, cell_idx, dot, d2;
      bit          last_col, last_row;
      glyph_beat_t beat;
      w = (image_width == 0) ? 1 : (image_width > MAX_WIDTH) ? MAX_WIDTH : image_width;
      h = (image_height == 0) ? 1 : (image_height > MAX_HEIGHT) ? MAX_HEIGHT : image_height;
      // counts left past the edge by a size change stick to the last column or row
      x = (col_pos >= w) ? w - 1 : col_pos;
      y = (row_pos >= h) ? h - 1 : row_pos;
      last_col = (x + 1 >= w);
      last_row = (y + 1 >= h);
      cell_idx = x / 2;
      if (cell_idx >= CELL_COLUMNS) cell_idx = CELL_COLUMNS - 1;
      d2 = dist_sq(px[7:0], target_r) + dist_sq(px[15:8], target_g)
         + dist_sq(px[23:16], target_b);
      if (d2 <= int'(sensitivity) * int'(sensitivity)) begin
        if (y % 4 == 3) dot = 6 + x % 2;
        else dot = (x % 2 == 1) ? y % 4 + 3 : y % 4;
        cell_dots[cell_idx][dot] = 1'b1;
      end
      // right and bottom padding close a cell early
      if ((y % 4 == 3 || last_row) && (x % 2 == 1 || last_col)) begin
        beat.glyph     = GLYPH_BASE + GLYPH_W'(cell_dots[cell_idx]);
        beat.line_end  = last_col;
        beat.image_end = last_col && last_row;
        expected_glyphs.push_back(beat);
        cell_dots[cell_idx] = '0;
      end
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : y + 1;
      end else begin
        col_pos = x + 1;
        row_pos = y;
      end
    endfunction

    function void check_glyph(glyph_beat_t seen);
      glyph_beat_t want;
      if (expected_glyphs.size() == 0) begin
        glyph_errors++;
        if (glyph_errors <= 10)
          $display("unexpected glyph beat: glyph %h line_end %b image_end %b",
                   seen.glyph, seen.line_end, seen.image_end);
        return;
      end
      want = expected_glyphs.pop_front();
      if (seen !== want) begin
        glyph_errors++;
        if (glyph_errors <= 10)
          $display("glyph mismatch: expected glyph %h line_end %b image_end %b, got %h %b %b",
                   want.glyph, want.line_end, want.image_end,
                   seen.glyph, seen.line_end, seen.image_end);
      end
    endfunction

    function int outstanding();
      return expected_glyphs.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cell_glyph_tracker tracker = new();
  int ready_stall_odds = 8;

  color_match_braille_cell_packer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #(LIMIT_TIME);
    $display("*** FAILED ***");
    $finish;
  end

  // glyph sink back-pressure in bursts
  initial begin
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (ready_stall_odds != 0 && $urandom_range(1, ready_stall_odds) == 1) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1)
      tracker.check_glyph(glyph_beat_t'({m_tdata[GLYPH_W-1:0], m_tlast, m_tuser}));
  end

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.write_reg(idx, value);
  endtask

  task automatic send_pixel(logic [IN_TDATA_W-1:0] px);
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.note_pixel(px);
  endtask

  // let every glyph out, then give in-flight pixels time to reach the cell store
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IN_TDATA_W-1:0] pick_pixel();
    case ($urandom_range(0, 3))
      0: return {tracker.target_b, tracker.target_g, tracker.target_r};
      1: return {tracker.target_b ^ 8'($urandom_range(0, 7)),
                 tracker.target_g ^ 8'($urandom_range(0, 7)),
                 tracker.target_r ^ 8'($urandom_range(0, 7))};
      2: return IN_TDATA_W'($urandom);
      default: return {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
    endcase
  endfunction

  initial begin
    int sent;
    int phase;
    int count;
    int pause_at;
    int gap_odds;
    bit calm;
    bit new_size;
    logic [WIDTH_REG_W-1:0]  w_val;
    logic [HEIGHT_REG_W-1:0] h_val;
    logic [SENS_W-1:0]       s_val;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // odd width and a short last band: padding on both edges
    cfg_write(CFG_IMAGE_WIDTH, 13'd3);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd5);
    cfg_write(CFG_TARGET_RED, 13'h40);
    cfg_write(CFG_TARGET_GREEN, 13'h80);
    cfg_write(CFG_TARGET_BLUE, 13'hc0);
    cfg_write(CFG_SENSITIVITY, 13'd0);
    cfg_write(CFG_SPARE_6, '1);
    cfg_write(CFG_SPARE_7, '1);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 15; i++) begin
      case (i % 4)
        0: send_pixel({8'hc0, 8'h80, 8'h40});
        1: send_pixel('0);
        2: send_pixel('1);
        default: send_pixel({8'hc0, 8'h80, 8'h41});
      endcase
    end
    settle();

    // zero sizes act as one pixel per image; sensitivity past the cube diagonal matches all
    cfg_write(CFG_IMAGE_WIDTH, 13'd0);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd0);
    cfg_write(CFG_TARGET_RED, 13'hff);
    cfg_write(CFG_TARGET_GREEN, 13'hff);
    cfg_write(CFG_TARGET_BLUE, 13'hff);
    cfg_write(CFG_SENSITIVITY, 13'd511);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 3; i++) send_pixel(i == 0 ? '0 : IN_TDATA_W'($urandom));
    settle();

    // distance right on the threshold and just past it
    cfg_write(CFG_TARGET_RED, 13'd100);
    cfg_write(CFG_TARGET_GREEN, 13'd100);
    cfg_write(CFG_TARGET_BLUE, 13'd100);
    cfg_write(CFG_SENSITIVITY, 13'd3);
    cfg_valid <= 1'b0;
    send_pixel({8'd100, 8'd100, 8'd103});
    send_pixel({8'd101, 8'd102, 8'd102});
    send_pixel({8'd102, 8'd102, 8'd102});
    settle();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      calm = (sent >= RANDOM_PIXELS - CALM_PIXELS);
      new_size = 1'b1;
      case (phase)
        0: begin w_val = '1; h_val = 13'd1; count = 1024; end  // width past the maximum
        1: begin w_val = 11'd1; h_val = '1; count = 41; end    // height past the maximum
        2: begin w_val = 11'd1; h_val = 13'd3; count = 10; end // row already past new height
        3: begin w_val = 11'd7; h_val = 13'd6; count = 10; end
        4: begin w_val = 11'd2; h_val = 13'd6; count = 10; end // column past new width
        default: begin
          new_size = ($urandom_range(0, 3) != 0);
          w_val = ($urandom_range(0, 15) == 0) ? 11'd1024 : 11'($urandom_range(0, 9));
          h_val = 13'($urandom_range(0, 11));
          count = $urandom_range(1, 120);
        end
      endcase
      if (new_size) begin
        cfg_write(CFG_IMAGE_WIDTH, {2'($urandom), w_val});
        cfg_write(CFG_IMAGE_HEIGHT, h_val);
      end
      case ($urandom_range(0, 5))
        0: s_val = '0;
        1: s_val = 9'd442;
        2: s_val = 9'($urandom_range(443, 511));
        default: s_val = 9'($urandom_range(1, 40));
      endcase
      cfg_write(CFG_TARGET_RED, {5'($urandom), 8'($urandom)});
      cfg_write(CFG_TARGET_GREEN, {5'($urandom), 8'($urandom)});
      cfg_write(CFG_TARGET_BLUE, {5'($urandom), 8'($urandom)});
      cfg_write(CFG_SENSITIVITY, {4'($urandom), s_val});
      cfg_valid <= 1'b0;

      if (calm) begin
        ready_stall_odds = 0;
        gap_odds = 0;
      end else begin
        ready_stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 16);
        gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 16);
      end
      pause_at = (!calm && (phase == 2 || $urandom_range(0, 3) == 0))
               ? $urandom_range(0, count - 1) : -1;

      for (int i = 0; i < count; i++) begin
        if (i == pause_at) begin
          // hold the source until the glyph stream has caught up
          s_tvalid <= 1'b0;
          do @(posedge clk); while (tracker.outstanding() != 0);
        end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        send_pixel(pick_pixel());
      end
      sent += count;
      phase++;
      settle();
    end

    if (tracker.glyph_errors == 0 && tracker.outstanding() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
design/cmbcp_pkg.sv
design/cmbcp_front.sv
design/cmbcp_queue.sv
design/cmbcp_back.sv
design/color_match_braille_cell_packer.sv
design/cmbcp_checker.sv
test/color_match_braille_cell_packer_tb.sv
